// File: hw/rtl/ffb_effect_block_pool_macros.svh
// Assertion helpers for the effect block pool.
`ifndef FFB_EFFECT_BLOCK_POOL_MACROS_SVH
`define FFB_EFFECT_BLOCK_POOL_MACROS_SVH

// Same-cycle implication.
`define FFB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffb assertion failed");

// Next-cycle implication.
`define FFB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffb assertion failed");

`endif

// File: hw/rtl/ffb_pkg.sv
package ffb_pkg;

  localparam logic [3:0] FN_CREATE = 4'd0;
  localparam logic [3:0] FN_FREE   = 4'd1;
  localparam logic [3:0] FN_START  = 4'd2;
  localparam logic [3:0] FN_SOLO   = 4'd3;
  localparam logic [3:0] FN_STOP   = 4'd4;
  localparam logic [3:0] FN_CTRL   = 4'd5;
  localparam logic [3:0] FN_QUERY  = 4'd6;
  localparam logic [3:0] FN_TIMING = 4'd7;
  localparam logic [3:0] FN_GAIN   = 4'd8;

  localparam logic [2:0] CC_ENABLE  = 3'd1;
  localparam logic [2:0] CC_DISABLE = 3'd2;
  localparam logic [2:0] CC_STOPALL = 3'd3;
  localparam logic [2:0] CC_RESET   = 3'd4;
  localparam logic [2:0] CC_PAUSE   = 3'd5;
  localparam logic [2:0] CC_CONT    = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] FLAG_ALLOC = 2'b01;
  localparam int         PLAY_BIT   = 1;

  localparam logic [7:0]  IDX_ALL      = 8'hFF;
  localparam logic [7:0]  LOOP_INF     = 8'hFF;
  localparam logic [7:0]  TRIG_NONE    = 8'hFF;
  localparam logic [15:0] DUR_INF      = 16'hFFFF;
  localparam logic [15:0] REP_NEVER    = 16'hFFFF;
  localparam logic [7:0]  GAIN_RESET   = 8'hFF;
  localparam logic [4:0]  STATUS_RESET = 5'h1E;
  localparam logic [4:0]  STATUS_ACT   = 5'h02;
  localparam logic [4:0]  STATUS_PAUSE = 5'h01;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_FIND, S_READ, S_MOD, S_CONT, S_SUM, S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] base;
    logic [23:0] run;
    logic        inf;
    logic [15:0] delay;
    logic [7:0]  trig;
    logic [15:0] rep;
    logic [31:0] start;
    logic        latch;
  } entry_t;

endpackage

// File: hw/rtl/ffb_effect_block_pool.sv
// Effect block pool: one item at a time, entry data in a registered-read memory.
// A request is decoded, then goes through a free-entry search for create, an
// entry read-modify-write for start, solo, query or timing with a valid index,
// or a continue pass through the memory, before a scan of all entries.
// A new item is taken only in idle, after the last result is loaded. Reset clears
// all entries at once through per-entry valid bits, gain to 255, status to 0x1E.
module ffb_effect_block_pool
  import ffb_pkg::*;
#(
  parameter int NUM_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic [7:0]  block_index,
  input  logic [7:0]  effect_kind,
  input  logic [7:0]  loop_count,
  input  logic [2:0]  control_code,
  input  logic [15:0] duration_ms,
  input  logic [15:0] start_delay_ms,
  input  logic [7:0]  trigger_button,
  input  logic [15:0] repeat_interval_ms,
  input  logic [7:0]  gain_value,
  input  logic [31:0] now_ms,
  input  logic [7:0]  buttons,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_status,
  output logic [7:0]  given_index,
  output logic        is_playing,
  output logic [7:0]  playing_report,
  output logic [4:0]  device_status,
  output logic [7:0]  free_count,
  output logic [7:0]  gain_out
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int PW = $clog2(NUM_ENTRIES + 1);
  localparam logic [PW-1:0] LAST = PW'(NUM_ENTRIES - 1);
  localparam logic [PW-1:0] CNT_N = PW'(NUM_ENTRIES);

  state_t state, state_next;

  logic [3:0]  r_func;
  logic [7:0]  r_idx, r_kind, r_loops, r_trig, r_gain, r_btn;
  logic [2:0]  r_code;
  logic [15:0] r_dur, r_dly, r_rep;
  logic [31:0] r_now;

  logic [1:0]  flags [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid;
  entry_t      mem [NUM_ENTRIES];
  entry_t      rd_word;
  logic        rd_ok;

  logic [PW-1:0] sp, cnt;
  logic [31:0] pause_stamp;
  logic [7:0]  gain_reg;
  logic [4:0]  status_bits;

  logic [1:0]  res_status;
  logic [7:0]  res_given, nfree, report;
  logic        res_play;

  logic          idx_ok;
  logic          dec_bad;
  logic [IW-1:0] e, rd_addr, wa, cprev;
  logic [PW-1:0] p;
  logic          p_free;
  logic          we;
  entry_t        wd, w, mw;
  logic          mod_play, mod_set_play, mod_clr_play;
  logic          out_load;
  logic [31:0]   start_new, elapsed, cont_len;
  logic [32:0]   run_rep;
  logic          pressed;
  logic [2:0]    bsel;
  logic [7:0]    rpt_idx;

  assign idx_ok = (r_idx >= 8'd1) && (r_idx <= 8'(NUM_ENTRIES));
  assign dec_bad = !idx_ok && (((r_func == FN_FREE) && (r_idx != IDX_ALL)) ||
                               r_func == FN_START || r_func == FN_SOLO ||
                               r_func == FN_STOP || r_func == FN_QUERY ||
                               r_func == FN_TIMING);
  assign e = IW'(r_idx - 8'd1);
  assign p = (sp >= CNT_N) ? '0 : sp;
  assign p_free = (flags[p[IW-1:0]] == 2'b00);
  assign w = rd_ok ? rd_word : '0;
  assign cprev = IW'(cnt - PW'(1));
  assign cont_len = r_now - pause_stamp;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign rpt_idx = 8'(cnt) + 8'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC: begin
        if (r_func == FN_CREATE) state_next = S_FIND;
        else if (idx_ok && (r_func == FN_START || r_func == FN_SOLO ||
                            r_func == FN_QUERY || r_func == FN_TIMING))
          state_next = S_READ;
        else if (r_func == FN_CTRL && r_code == CC_CONT) state_next = S_CONT;
        else state_next = S_SUM;
      end
      S_FIND: if (p_free || cnt == LAST) state_next = S_SUM;
      S_READ: state_next = S_MOD;
      S_MOD:  state_next = S_SUM;
      S_CONT: if (cnt == CNT_N) state_next = S_SUM;
      S_SUM:  if (cnt == LAST) state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    start_new = r_now + {16'd0, w.delay};
    elapsed = r_now - w.start;
    run_rep = {9'd0, w.run} + {17'd0, w.rep};
    bsel = 3'(w.trig - 8'd1);
    pressed = (w.trig >= 8'd1) && (w.trig <= 8'd8) && r_btn[bsel];
    mw = w;
    mod_play = 1'b0;
    mod_set_play = 1'b0;
    mod_clr_play = 1'b0;
    priority if (r_func == FN_START || r_func == FN_SOLO) begin
      mod_set_play = 1'b1;
      mw.run = (r_loops != LOOP_INF && r_loops != 8'd0) ?
               ({16'd0, r_loops} * {8'd0, w.base}) : {8'd0, w.base};
      mw.inf = (r_loops == LOOP_INF) || (w.base == DUR_INF);
      if (w.trig != TRIG_NONE) begin
        mw.start = '0;
        mw.latch = 1'b0;
      end else begin
        mw.start = start_new;
      end
    end else if (r_func == FN_TIMING) begin
      mw.kind = r_kind;
      mw.base = r_dur;
      mw.run = {8'd0, r_dur};
      mw.inf = (r_dur == DUR_INF);
      mw.delay = r_dly;
      mw.trig = r_trig;
      mw.rep = r_rep;
    end else if (flags[e][PLAY_BIT]) begin
      if (w.trig != TRIG_NONE) begin
        if (w.trig == 8'd0) begin
          mod_play = 1'b0;
        end else if (!pressed) begin
          mw.latch = 1'b0;
        end else if (!w.latch) begin
          mw.start = start_new;
          mw.latch = 1'b1;
          mod_play = !(r_now < start_new);
        end else if (w.inf || elapsed < {8'd0, w.run}) begin
          mod_play = 1'b1;
        end else if (w.rep == REP_NEVER) begin
          mod_play = 1'b0;
        end else if ({1'b0, elapsed} < run_rep) begin
          mod_play = 1'b0;
        end else begin
          mw.start = start_new;
          mod_play = 1'b1;
        end
      end else if (r_now < w.start) begin
        mod_play = 1'b0;
      end else if (!w.inf && elapsed >= {8'd0, w.run}) begin
        mod_clr_play = 1'b1;
      end else begin
        mod_play = 1'b1;
      end
    end
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    rd_addr = e;
    we = 1'b0;
    wa = e;
    wd = mw;
    unique case (state)
      S_FIND: begin
        wa = p[IW-1:0];
        wd = '0;
        wd.kind = r_kind;
        we = p_free;
      end
      S_MOD: we = 1'b1;
      S_CONT: begin
        rd_addr = cnt[IW-1:0];
        wa = cprev;
        wd = w;
        wd.start = w.start + cont_len;
        we = (cnt != '0) && flags[cprev][PLAY_BIT] && !(pause_stamp < w.start);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
    rd_ok <= valid[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      valid <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) flags[i] <= 2'b00;
      sp <= '0;
      cnt <= '0;
      pause_stamp <= '0;
      gain_reg <= GAIN_RESET;
      status_bits <= STATUS_RESET;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else cnt <= cnt + PW'(1);
      if (we) valid[wa] <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: if (in_valid) begin
          r_func <= func;
          r_idx <= block_index;
          r_kind <= effect_kind;
          r_loops <= loop_count;
          r_code <= control_code;
          r_dur <= duration_ms;
          r_dly <= start_delay_ms;
          r_trig <= trigger_button;
          r_rep <= repeat_interval_ms;
          r_gain <= gain_value;
          r_now <= now_ms;
          r_btn <= buttons;
        end
        S_DEC: begin
          res_status <= dec_bad ? ST_INVALID : ST_OK;
          res_given <= '0;
          res_play <= 1'b0;
          nfree <= '0;
          report <= '0;
          unique case (r_func)
            FN_FREE: begin
              if (r_idx == IDX_ALL) begin
                valid <= '0;
                for (int i = 0; i < NUM_ENTRIES; i++) flags[i] <= 2'b00;
                sp <= '0;
              end else if (idx_ok) begin
                flags[e] <= 2'b00;
                sp <= PW'(e);
              end
            end
            FN_SOLO: begin
              if (idx_ok)
                for (int i = 0; i < NUM_ENTRIES; i++) flags[i][PLAY_BIT] <= 1'b0;
            end
            FN_STOP: begin
              if (idx_ok) flags[e][PLAY_BIT] <= 1'b0;
            end
            FN_GAIN: gain_reg <= r_gain;
            FN_CTRL: begin
              unique case (r_code)
                CC_ENABLE:  status_bits <= status_bits | STATUS_ACT;
                CC_DISABLE: status_bits <= status_bits & ~STATUS_ACT;
                CC_STOPALL:
                  for (int i = 0; i < NUM_ENTRIES; i++) flags[i][PLAY_BIT] <= 1'b0;
                CC_RESET: begin
                  valid <= '0;
                  for (int i = 0; i < NUM_ENTRIES; i++) flags[i] <= 2'b00;
                  sp <= '0;
                  pause_stamp <= '0;
                  gain_reg <= GAIN_RESET;
                  status_bits <= STATUS_RESET;
                end
                CC_PAUSE: begin
                  status_bits <= status_bits | STATUS_PAUSE;
                  pause_stamp <= r_now;
                end
                CC_CONT: status_bits <= status_bits & ~STATUS_PAUSE;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_FIND: begin
          sp <= p + PW'(1);
          if (p_free) begin
            flags[p[IW-1:0]] <= FLAG_ALLOC;
            res_given <= 8'(p) + 8'd1;
          end else if (cnt == LAST) begin
            res_status <= ST_FULL;
          end
        end
        S_MOD: begin
          res_play <= (r_func == FN_QUERY) && mod_play;
          if (mod_set_play) flags[e][PLAY_BIT] <= 1'b1;
          if (mod_clr_play) flags[e][PLAY_BIT] <= 1'b0;
        end
        S_SUM: begin
          if (flags[cnt[IW-1:0]] == 2'b00) nfree <= nfree + 8'd1;
          if (report == 8'd0 && flags[cnt[IW-1:0]][PLAY_BIT])
            report <= {rpt_idx[6:0], 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_status <= res_status;
      given_index <= res_given;
      is_playing <= res_play;
      playing_report <= report;
      device_status <= status_bits;
      free_count <= nfree;
      gain_out <= gain_reg;
    end
  end

`include "ffb_effect_block_pool_macros.svh"

  `FFB_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `FFB_ASSERT_IMP(a_status_code, out_valid, result_status != 2'd3)
  `FFB_ASSERT_IMP(a_given_ok, out_valid && given_index != 8'd0, result_status == ST_OK)
  `FFB_ASSERT_IMP(a_free_bound, out_valid, free_count <= 8'(NUM_ENTRIES))

endmodule
